>>> hw/rtl/tsd_pkg.sv
// Shared types, constants and arithmetic helpers for the scratchpad decoder.
package tsd_pkg;

    localparam logic [7:0]  CrcPolyRefl    = 8'h8C;
    localparam logic [15:0] OldTruncMask   = 16'hFFF0;
    localparam logic [7:0]  CountPerDegree = 8'h10;
    localparam logic [15:0] CountBias      = 16'd12;
    localparam logic [7:0]  ResMask        = 8'h60;
    localparam logic [7:0]  Res9Bit        = 8'h00;
    localparam logic [7:0]  Res10Bit       = 8'h20;
    localparam logic [7:0]  Res11Bit       = 8'h40;
    localparam logic [20:0] FahrOffset     = 21'd320;
    localparam logic [19:0] DivTenMagic    = 20'd838861;
    localparam int          DivTenShift    = 23;
    localparam logic signed [11:0] HeldWholeInit12 = -12'sd100;
    localparam logic signed [12:0] HeldWholeInit13 = -13'sd100;

    // One decode request handed from the front to the back.
    typedef struct packed {
        logic       crc_ok;
        logic       old_family;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte4;
        logic [7:0] byte6;
        logic [7:0] byte7;
    } tsd_req_t;

    typedef struct packed {
        logic              crc_ok;
        logic signed [11:0] celsius_whole;
        logic signed [4:0]  celsius_tenths;
        logic signed [12:0] fahrenheit_whole;
        logic signed [4:0]  fahrenheit_tenths;
    } tsd_res_t;

    typedef struct packed {
        logic signed [20:0] quot;
        logic signed [4:0]  rem;
    } div10_t;

    // Reflected CRC-8, one bit per step, LSB first.
    function automatic logic [7:0] crc_fold(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = data;
        for (int k = 0; k < 8; k++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CrcPolyRefl;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

    // Signed division by ten truncating toward zero, with a signed remainder.
    // The reciprocal is exact for magnitudes below 2^21.
    function automatic div10_t div10(input logic signed [20:0] x);
        logic [20:0] xu;
        logic [20:0] mag;
        logic [40:0] prod;
        logic [20:0] q;
        logic [20:0] q10;
        logic [4:0]  r;
        div10_t      res;
        xu   = x;
        mag  = xu[20] ? (~xu + 21'd1) : xu;
        prod = {20'd0, mag} * {21'd0, DivTenMagic};
        q    = {3'd0, prod[40:DivTenShift]};
        q10  = (q << 3) + (q << 1);
        r    = 5'(mag - q10);
        res.quot = xu[20] ? $signed(~q + 21'd1) : $signed(q);
        res.rem  = xu[20] ? $signed(~r + 5'd1) : $signed(r);
        return res;
    endfunction

endpackage

>>> hw/rtl/tsd_front.sv
// Front end: byte counting, running CRC, capture of the bytes the decode needs.
module tsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_start,
    input  logic              old_family,
    output logic              push,
    output tsd_pkg::tsd_req_t push_req,
    input  logic              queue_full
);
    import tsd_pkg::*;

    logic [3:0] byte_index_reg, byte_index_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] b0_reg, b1_reg, b4_reg, b6_reg, b7_reg;
    logic [3:0] idx;
    logic [7:0] crc_cur;
    logic       take;

    assign in_ready = !queue_full;
    assign take     = in_valid && in_ready;
    assign idx      = in_start ? 4'd0 : byte_index_reg;
    assign crc_cur  = in_start ? 8'd0 : crc_reg;

    // Index eight is the check byte; it closes the frame.
    assign push = take && idx[3];

    always_comb begin
        push_req.crc_ok     = (crc_cur == in_byte);
        push_req.old_family = old_family;
        push_req.byte0      = b0_reg;
        push_req.byte1      = b1_reg;
        push_req.byte4      = b4_reg;
        push_req.byte6      = b6_reg;
        push_req.byte7      = b7_reg;
    end

    always_comb begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        if (take) begin
            if (idx[3]) begin
                byte_index_next = 4'd0;
                crc_next        = 8'd0;
            end else begin
                byte_index_next = idx + 4'd1;
                crc_next        = crc_fold(crc_cur, in_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= 4'd0;
            crc_reg        <= 8'd0;
        end else begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !idx[3]) begin
            case (idx[2:0])
                3'd0: b0_reg <= in_byte;
                3'd1: b1_reg <= in_byte;
                3'd4: b4_reg <= in_byte;
                3'd6: b6_reg <= in_byte;
                3'd7: b7_reg <= in_byte;
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/tsd_queue.sv
// Two-entry request queue between the front and the back.
module tsd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tsd_pkg::tsd_req_t push_req,
    output logic              full,
    input  logic              pop,
    output tsd_pkg::tsd_req_t pop_req,
    output logic              empty
);
    import tsd_pkg::*;

    tsd_req_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_req = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

>>> hw/rtl/tsd_back.sv
// Back end: temperature conversion sequencer, held values and output register.
module tsd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              queue_empty,
    input  tsd_pkg::tsd_req_t req,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tsd_pkg::tsd_res_t out_res
);
    import tsd_pkg::*;

    localparam logic [2:0] BK_IDLE = 3'd0;
    localparam logic [2:0] BK_RAW  = 3'd1;
    localparam logic [2:0] BK_C10  = 3'd2;
    localparam logic [2:0] BK_CDIV = 3'd3;
    localparam logic [2:0] BK_FDIV = 3'd4;
    localparam logic [2:0] BK_EMIT = 3'd5;

    logic [2:0]         state_reg, state_next;
    tsd_req_t           req_reg;
    logic [15:0]        raw_reg, raw_next;
    logic signed [15:0] c10_reg, c10_next;
    logic signed [20:0] t_reg;
    logic signed [20:0] f10_reg;
    logic signed [11:0] cw_reg;
    logic signed [4:0]  ct_reg;
    logic signed [11:0] held_cw_reg;
    logic signed [4:0]  held_ct_reg;
    logic signed [12:0] held_fw_reg;
    logic signed [4:0]  held_ft_reg;
    logic               out_valid_reg;
    tsd_res_t           out_res_reg, emit_res;
    logic               emit;
    logic [15:0]        shifted;
    logic [7:0]         res_sel;
    logic signed [19:0] x10;
    logic signed [19:0] x10_adj;
    div10_t             cdiv, fdiv, fdiv2;

    assign pop       = (state_reg == BK_IDLE) && !queue_empty;
    assign emit      = (state_reg == BK_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Family adjustment of the raw reading.
    always_comb begin
        raw_next = {req_reg.byte1, req_reg.byte0};
        shifted  = raw_next << 3;
        res_sel  = req_reg.byte4 & ResMask;
        if (req_reg.old_family) begin
            if (req_reg.byte7 == CountPerDegree) begin
                raw_next = (shifted & OldTruncMask) + CountBias - {8'd0, req_reg.byte6};
            end else begin
                raw_next = shifted;
            end
        end else begin
            case (res_sel)
                Res9Bit:  raw_next = raw_next & 16'hFFF8;
                Res10Bit: raw_next = raw_next & 16'hFFFC;
                Res11Bit: raw_next = raw_next & 16'hFFFE;
                default:  raw_next = raw_next;
            endcase
        end
    end

    // Tenths of Celsius: raw times ten over sixteen, rounded toward zero.
    always_comb begin
        x10      = ($signed(20'(signed'(raw_reg))) <<< 3)
                 + ($signed(20'(signed'(raw_reg))) <<< 1);
        x10_adj  = x10 + (x10[19] ? 20'sd15 : 20'sd0);
        c10_next = 16'(x10_adj >>> 4);
    end

    assign cdiv  = div10(21'(c10_reg));
    assign fdiv  = div10(t_reg);
    assign fdiv2 = div10(f10_reg);

    always_comb begin
        emit_res.crc_ok = req_reg.crc_ok;
        if (req_reg.crc_ok) begin
            emit_res.celsius_whole     = cw_reg;
            emit_res.celsius_tenths    = ct_reg;
            emit_res.fahrenheit_whole  = 13'(fdiv2.quot);
            emit_res.fahrenheit_tenths = fdiv2.rem;
        end else begin
            emit_res.celsius_whole     = held_cw_reg;
            emit_res.celsius_tenths    = held_ct_reg;
            emit_res.fahrenheit_whole  = held_fw_reg;
            emit_res.fahrenheit_tenths = held_ft_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop) begin
                    state_next = req.crc_ok ? BK_RAW : BK_EMIT;
                end
            end
            BK_RAW:  state_next = BK_C10;
            BK_C10:  state_next = BK_CDIV;
            BK_CDIV: state_next = BK_FDIV;
            BK_FDIV: state_next = BK_EMIT;
            BK_EMIT: begin
                if (emit) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            held_cw_reg   <= HeldWholeInit12;
            held_ct_reg   <= 5'sd0;
            held_fw_reg   <= HeldWholeInit13;
            held_ft_reg   <= 5'sd0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (emit && req_reg.crc_ok) begin
                held_cw_reg <= emit_res.celsius_whole;
                held_ct_reg <= emit_res.celsius_tenths;
                held_fw_reg <= emit_res.fahrenheit_whole;
                held_ft_reg <= emit_res.fahrenheit_tenths;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            req_reg <= req;
        end
        if (state_reg == BK_RAW) begin
            raw_reg <= raw_next;
        end
        if (state_reg == BK_C10) begin
            c10_reg <= c10_next;
        end
        if (state_reg == BK_CDIV) begin
            cw_reg <= 12'(cdiv.quot);
            ct_reg <= cdiv.rem;
            t_reg  <= (21'(c10_reg) <<< 4) + (21'(c10_reg) <<< 1);
        end
        if (state_reg == BK_FDIV) begin
            f10_reg <= fdiv.quot + $signed(FahrOffset);
        end
        if (emit) begin
            out_res_reg <= emit_res;
        end
    end

endmodule

>>> hw/rtl/temp_sensor_scratchpad_decode.sv
// Top level of the thermometer scratchpad decoder.
//
//   Channel  Direction  Payload
//   s_       in         tdata: scratch_byte; tuser: frame_start
//   m_       out        tdata: celsius_whole, celsius_tenths, fahrenheit_whole,
//                       fahrenheit_tenths; tuser: crc_ok
//   cfg_     in         cfg_data: family_is_old_type
//
// Input bytes are taken one per cycle whenever the two-entry request queue has room.
// The ninth byte of a frame queues one decode request. For a good CRC the back end's
// conversion sequencer, with one divide-by-ten unit per step, runs raw, Celsius-tenths,
// Celsius-divide and Fahrenheit-divide states before emitting; a bad CRC skips them.
// Reset clears byte count, CRC, queue and sequencer, and loads the held values.
// A stalled result waits in the output register while input bytes keep flowing until the queue is full.
module temp_sensor_scratchpad_decode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scratch_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [11:0] celsius_whole, [16:12] celsius_tenths,
                                   // [29:17] fahrenheit_whole, [34:30] fahrenheit_tenths
    output logic        m_tuser,   // [0] crc_ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // [0] family_is_old_type
);
    import tsd_pkg::*;

    logic     family_reg;
    logic     push, pop, queue_full, queue_empty;
    tsd_req_t push_req, pop_req;
    tsd_res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            family_reg <= 1'b0;
        end else if (cfg_valid) begin
            family_reg <= cfg_data;
        end
    end

    tsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_start   (s_tuser),
        .old_family (family_reg),
        .push       (push),
        .push_req   (push_req),
        .queue_full (queue_full)
    );

    tsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .full     (queue_full),
        .pop      (pop),
        .pop_req  (pop_req),
        .empty    (queue_empty)
    );

    tsd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .req         (pop_req),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tuser = res.crc_ok;
    assign m_tdata = {5'd0, res.fahrenheit_tenths, res.fahrenheit_whole,
                      res.celsius_tenths, res.celsius_whole};

endmodule
